>>> src/sekc_pkg.sv
package sekc_pkg;

  // Field widths of the data words.
  localparam int PIX_W  = 8;
  localparam int RESP_W = 11;
  localparam int IDX_W  = 9;

  // Configuration port and register layout.
  localparam int CFG_REG_W    = 11;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_SIZE_RST = 11;
  localparam int SIZE_MIN     = 3;

  // Register index, taken from the word-aligned address bit.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Input word: one pixel in raster order.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_word_t;

  // Output word: one strided window response.
  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     last_of_frame;
  } out_word_t;

  // Result decision for one pixel, computed from its frame position.
  typedef struct packed {
    logic             emit;
    logic             last_of_frame;
    logic [IDX_W-1:0] out_row;
    logic [IDX_W-1:0] out_col;
  } res_tag_t;

  // One line store entry: the row two above and the row just above.
  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
  } line_pair_t;

endpackage

>>> src/strided_edge_kernel_convolver_unit.sv
// Channel  Direction  Handshake             Word
// in       input      in_valid / in_stall   in_data (pixel, frame_start)
// out      output     out_valid / out_stall out_data (response, out_row, out_col, last_of_frame)
// cfg      input      psel/penable/pready   frame_width at 0x0, frame_height at 0x4
//
// One pixel word is taken every clock while in_stall is low; the pixel is held in the read
// stage register and its result is then taken into the output register.
// The rate is set by the single line store memory, read and written once per pixel.
// After reset the line store is zeroed one entry per cycle, all MAX_WIDTH entries,
// with in_stall high; configuration writes are taken during that time.
// A stalled result holds in the output register. Pixels without a result keep flowing, and
// past the sweep the input stalls only while a second result waits behind it in the read stage.
module strided_edge_kernel_convolver_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  sekc_pkg::in_word_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output sekc_pkg::out_word_t                   out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [sekc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [sekc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [sekc_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WSZ_W = $clog2(MAX_WIDTH + 1);
  localparam int HSZ_W = $clog2(MAX_HEIGHT + 1);
  localparam int W_RST = (sekc_pkg::CFG_SIZE_RST > MAX_WIDTH) ?
                         MAX_WIDTH : sekc_pkg::CFG_SIZE_RST;
  localparam int H_RST = (sekc_pkg::CFG_SIZE_RST > MAX_HEIGHT) ?
                         MAX_HEIGHT : sekc_pkg::CFG_SIZE_RST;

  logic [sekc_pkg::CFG_REG_W-1:0] frame_width_r, frame_height_r;
  logic [WSZ_W-1:0]               w_use_r, w_clamp;
  logic [HSZ_W-1:0]               h_use_r, h_clamp;
  logic [31:0]                    wr_ext;
  logic                           cfg_wr;

  logic                           clr_busy_r;
  logic [COL_W-1:0]               clr_addr_r;

  logic                           in_acc;
  logic [COL_W-1:0]               col_cur;
  sekc_pkg::res_tag_t             tag_cur;

  logic                           s1_vld_r;
  logic [COL_W-1:0]               s1_col_r;
  logic [sekc_pkg::PIX_W-1:0]     s1_px_r;
  sekc_pkg::res_tag_t             s1_tag_r;
  logic                           fwd_hit_r;
  sekc_pkg::line_pair_t           fwd_data_r;
  sekc_pkg::line_pair_t           rd_data, s1_pair, wr_data;
  logic                           s1_go, s1_free, s1_commit, out_go;
  logic                           mem_we;
  logic [COL_W-1:0]               mem_waddr;
  logic signed [sekc_pkg::RESP_W-1:0] s1_sum;

  logic                           out_vld_r;
  sekc_pkg::out_word_t            out_data_r;

  // Configuration registers, with the clamped size kept alongside.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_ext = 32'(pwdata[sekc_pkg::CFG_REG_W-1:0]);

  always_comb begin
    if (wr_ext < 32'(sekc_pkg::SIZE_MIN)) begin
      w_clamp = WSZ_W'(sekc_pkg::SIZE_MIN);
      h_clamp = HSZ_W'(sekc_pkg::SIZE_MIN);
    end else begin
      w_clamp = (wr_ext > 32'(MAX_WIDTH))  ? WSZ_W'(MAX_WIDTH)  : WSZ_W'(wr_ext);
      h_clamp = (wr_ext > 32'(MAX_HEIGHT)) ? HSZ_W'(MAX_HEIGHT) : HSZ_W'(wr_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= sekc_pkg::CFG_REG_W'(sekc_pkg::CFG_SIZE_RST);
      frame_height_r <= sekc_pkg::CFG_REG_W'(sekc_pkg::CFG_SIZE_RST);
      w_use_r        <= WSZ_W'(W_RST);
      h_use_r        <= HSZ_W'(H_RST);
    end else if (cfg_wr) begin
      if (paddr[sekc_pkg::CFG_ADDR_W-1] == sekc_pkg::REG_FRAME_WIDTH) begin
        frame_width_r <= pwdata[sekc_pkg::CFG_REG_W-1:0];
        w_use_r       <= w_clamp;
      end else begin
        frame_height_r <= pwdata[sekc_pkg::CFG_REG_W-1:0];
        h_use_r        <= h_clamp;
      end
    end
  end

  assign prdata = (paddr[sekc_pkg::CFG_ADDR_W-1] == sekc_pkg::REG_FRAME_HEIGHT) ?
                  sekc_pkg::CFG_DATA_W'(frame_height_r) :
                  sekc_pkg::CFG_DATA_W'(frame_width_r);

  // Zeroing sweep of the line store after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + COL_W'(1);
      if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Flow control: a pixel without a result never waits for the output.
  assign out_go    = !out_vld_r || !out_stall;
  assign s1_go     = !s1_tag_r.emit || out_go;
  assign s1_free   = !s1_vld_r || s1_go;
  assign s1_commit = s1_vld_r && s1_go;
  assign in_stall  = clr_busy_r || !s1_free;
  assign in_acc    = in_valid && !in_stall;

  sekc_pos_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_acc),
    .frame_start (in_data.frame_start),
    .w_use       (w_use_r),
    .h_use       (h_use_r),
    .col_cur     (col_cur),
    .tag         (tag_cur)
  );

  // Read stage: the pixel and its column are held while the line store is read.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_free) begin
      s1_vld_r <= in_acc;
    end
  end

  // The entry being written back this cycle is forwarded if the same column is read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_col_r   <= col_cur;
      s1_px_r    <= in_data.pixel;
      s1_tag_r   <= tag_cur;
      fwd_hit_r  <= s1_commit && (s1_col_r == col_cur);
      fwd_data_r <= wr_data;
    end
  end

  assign s1_pair = fwd_hit_r ? fwd_data_r : rd_data;

  // Write back: the middle row moves up and the new pixel becomes the middle row.
  always_comb begin
    wr_data.upper  = s1_pair.middle;
    wr_data.middle = s1_px_r;
  end

  assign mem_we    = clr_busy_r || s1_commit;
  assign mem_waddr = clr_busy_r ? clr_addr_r : s1_col_r;

  sekc_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (clr_busy_r ? '0 : wr_data),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (rd_data)
  );

  sekc_window_calc u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .shift (s1_commit),
    .top   (s1_pair.upper),
    .mid   (s1_pair.middle),
    .px    (s1_px_r),
    .sum   (s1_sum)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_go) begin
      out_vld_r <= s1_commit && s1_tag_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_go && s1_commit && s1_tag_r.emit) begin
      out_data_r.response      <= s1_sum;
      out_data_r.out_row       <= s1_tag_r.out_row;
      out_data_r.out_col       <= s1_tag_r.out_col;
      out_data_r.last_of_frame <= s1_tag_r.last_of_frame;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

>>> src/sekc_line_mem.sv
module sekc_line_mem #(
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  sekc_pkg::line_pair_t  wr_data,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output sekc_pkg::line_pair_t  rd_data
);

  sekc_pkg::line_pair_t mem [DEPTH];
  sekc_pkg::line_pair_t rd_data_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> src/sekc_pos_ctrl.sv
module sekc_pos_ctrl #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  localparam int COL_W = $clog2(MAX_WIDTH),
  localparam int ROW_W = $clog2(MAX_HEIGHT),
  localparam int WSZ_W = $clog2(MAX_WIDTH + 1),
  localparam int HSZ_W = $clog2(MAX_HEIGHT + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic                frame_start,
  input  logic [WSZ_W-1:0]    w_use,
  input  logic [HSZ_W-1:0]    h_use,
  output logic [COL_W-1:0]    col_cur,
  output sekc_pkg::res_tag_t  tag
);

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [ROW_W-1:0] row_cur;
  logic [WSZ_W-1:0] col_ext, col_inc, last_c, w_m1;
  logic [HSZ_W-1:0] row_ext, row_inc, last_r, h_m1;
  logic [COL_W-1:0] col_m2;
  logic [ROW_W-1:0] row_m2;
  logic             wrap_col, wrap_row;

  // A frame start pulls the position back to the origin.
  assign col_cur = frame_start ? '0 : col_r;
  assign row_cur = frame_start ? '0 : row_r;
  assign col_ext = WSZ_W'(col_cur);
  assign row_ext = HSZ_W'(row_cur);
  assign col_inc = col_ext + WSZ_W'(1);
  assign row_inc = row_ext + HSZ_W'(1);
  assign wrap_col = (col_inc >= w_use);
  assign wrap_row = (row_inc >= h_use);

  // Raster position update.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (advance) begin
      if (wrap_col) begin
        col_nxt = '0;
        row_nxt = wrap_row ? '0 : ROW_W'(row_inc);
      end else begin
        col_nxt = COL_W'(col_inc);
        row_nxt = row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Last even row and column inside the frame.
  assign w_m1   = w_use - WSZ_W'(1);
  assign h_m1   = h_use - HSZ_W'(1);
  assign last_c = {w_m1[WSZ_W-1:1], 1'b0};
  assign last_r = {h_m1[HSZ_W-1:1], 1'b0};
  assign col_m2 = col_cur - COL_W'(2);
  assign row_m2 = row_cur - ROW_W'(2);

  // A window is complete on even row and column, two or more into the frame.
  always_comb begin
    tag.emit = (row_ext >= HSZ_W'(2)) && (col_ext >= WSZ_W'(2)) &&
               (row_ext < h_use) && (col_ext < w_use) &&
               !row_cur[0] && !col_cur[0];
    tag.last_of_frame = (row_ext == last_r) && (col_ext == last_c);
    tag.out_row = sekc_pkg::IDX_W'(row_m2 >> 1);
    tag.out_col = sekc_pkg::IDX_W'(col_m2 >> 1);
  end

endmodule

>>> src/sekc_window_calc.sv
module sekc_window_calc (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 shift,
  input  logic [sekc_pkg::PIX_W-1:0]           top,
  input  logic [sekc_pkg::PIX_W-1:0]           mid,
  input  logic [sekc_pkg::PIX_W-1:0]           px,
  output logic signed [sekc_pkg::RESP_W-1:0]   sum
);

  // Two older window columns; the newest column arrives on the inputs.
  logic [sekc_pkg::PIX_W-1:0] t1_r, t2_r, m1_r, m2_r, b1_r, b2_r;
  logic [sekc_pkg::PIX_W+1:0] pos_sum, neg_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_r <= '0;
      t2_r <= '0;
      m1_r <= '0;
      m2_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
    end else if (shift) begin
      t1_r <= t2_r;
      t2_r <= top;
      m1_r <= m2_r;
      m2_r <= mid;
      b1_r <= b2_r;
      b2_r <= px;
    end
  end

  // Combined kernel -1 1 1 / -1 0 1 / -1 -1 1 over the shifted window.
  assign pos_sum = 10'(t2_r) + 10'(top) + 10'(mid) + 10'(px);
  assign neg_sum = 10'(t1_r) + 10'(m1_r) + 10'(b1_r) + 10'(b2_r);
  assign sum = $signed({1'b0, pos_sum}) - $signed({1'b0, neg_sum});

endmodule

>>> src/sekc_checker.sv
module sekc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input sekc_pkg::in_word_t                    in_data,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input sekc_pkg::out_word_t                   out_data,
  input logic                                  psel,
  input logic                                  penable,
  input logic                                  pwrite,
  input logic [sekc_pkg::CFG_ADDR_W-1:0]       paddr,
  input logic [sekc_pkg::CFG_DATA_W-1:0]       pwdata,
  input logic [sekc_pkg::CFG_DATA_W-1:0]       prdata,
  input logic                                  pready
);

  // Coming out of reset the block is sweeping its line store and holds no result.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("input not stalled or result present after reset");

  // A stalled input word stays offered and unchanged.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input word changed");

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // The combined kernel response stays within the reach of 8-bit pixels.
  a_resp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.response) >= -1020) &&
                  ($signed(out_data.response) <= 1020))
    else $error("response out of range");

  // A written frame width reads back on the next cycle.
  a_width_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && pready &&
    (paddr[sekc_pkg::CFG_ADDR_W-1] == sekc_pkg::REG_FRAME_WIDTH) |=>
    !psel || pwrite || (paddr[sekc_pkg::CFG_ADDR_W-1] != sekc_pkg::REG_FRAME_WIDTH) ||
    (prdata[sekc_pkg::CFG_REG_W-1:0] == $past(pwdata[sekc_pkg::CFG_REG_W-1:0])))
    else $error("frame width readback mismatch");

endmodule

bind strided_edge_kernel_convolver_unit sekc_checker u_sekc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);
